>>> src/pihr_pkg.sv
`timescale 1ns / 1ps

package pihr_pkg;

  // timestamp bits kept by the block, limited by the 32-bit port
  localparam int TIME_BITS = 32;
  localparam int FRAC_BITS = 8;
  localparam int TIME_W    = (TIME_BITS < 32) ? TIME_BITS : 32;

  // port widths
  localparam int STAMP_W    = 32;
  localparam int INTERVAL_W = 32;
  localparam int RATE_W     = 24;

  // rate = (60000 << FRAC_BITS) / interval, one quotient bit per step
  localparam int BEAT_MS_PER_MIN = 60000;
  localparam int DIV_BITS        = 16 + FRAC_BITS;
  localparam int STEP_W          = $clog2(DIV_BITS);
  localparam logic [DIV_BITS-1:0] DIVIDEND = DIV_BITS'(BEAT_MS_PER_MIN) << FRAC_BITS;
  localparam int QUO_W = (DIV_BITS > RATE_W) ? DIV_BITS : RATE_W;
  localparam logic [QUO_W-1:0] RATE_MAX = QUO_W'((64'd1 << RATE_W) - 64'd1);

  // one rising edge with a known predecessor, handed from front to back
  typedef struct packed {
    logic [TIME_W-1:0] interval;
    logic              zero;
  } job_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_RUN,
    BACK_DONE
  } back_state_t;

endpackage

>>> src/pihr_if.sv
`timescale 1ns / 1ps

interface pihr_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time_ms;
  logic        pulse_level;
  logic        last_sample;

  modport source (output valid, sample_time_ms, pulse_level, last_sample, input ready);
  modport sink   (input valid, sample_time_ms, pulse_level, last_sample, output ready);
endinterface

interface pihr_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] interval_ms;
  logic [23:0] rate_fixed;
  logic        zero_interval;

  modport source (output valid, interval_ms, rate_fixed, zero_interval, input ready);
  modport sink   (input valid, interval_ms, rate_fixed, zero_interval, output ready);
endinterface

>>> src/pihr_front.sv
`timescale 1ns / 1ps

module pihr_front (
  input  logic                clk,
  input  logic                rst,
  pihr_sample_if.sink         samples,
  output logic                push_valid,
  input  logic                push_ready,
  output pihr_pkg::job_t      push_job
);

  logic                          previous_level;
  logic                          edge_seen;
  logic [pihr_pkg::TIME_W-1:0]   last_edge_time;
  logic [pihr_pkg::TIME_W-1:0]   stamp;
  logic                          rise;
  logic                          take;

  // every sample waits for room in the queue, edge or not
  assign samples.ready = push_ready;
  assign take  = samples.valid && push_ready;
  assign stamp = samples.sample_time_ms[pihr_pkg::TIME_W-1:0];
  assign rise  = !previous_level && samples.pulse_level;

  // interval wraps modulo the timestamp width
  assign push_job.interval = stamp - last_edge_time;
  assign push_job.zero     = (stamp == last_edge_time);
  assign push_valid        = samples.valid && rise && edge_seen;

  // edge history
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      edge_seen      <= 1'b0;
      last_edge_time <= '0;
    end else if (take) begin
      if (samples.last_sample) begin
        previous_level <= 1'b0;
        edge_seen      <= 1'b0;
        last_edge_time <= '0;
      end else begin
        previous_level <= samples.pulse_level;
        if (rise) begin
          edge_seen      <= 1'b1;
          last_edge_time <= stamp;
        end
      end
    end
  end

endmodule

>>> src/pihr_queue.sv
`timescale 1ns / 1ps

module pihr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  pihr_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output pihr_pkg::job_t pop_job
);

  pihr_pkg::job_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

>>> src/pihr_back.sv
`timescale 1ns / 1ps

module pihr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  pihr_pkg::job_t pop_job,
  pihr_result_if.source  results
);

  pihr_pkg::back_state_t            state;
  pihr_pkg::back_state_t            state_next;
  logic [pihr_pkg::TIME_W-1:0]      divisor;
  logic                             zero;
  logic [pihr_pkg::TIME_W-1:0]      remainder;
  logic [pihr_pkg::DIV_BITS-1:0]    quotient;
  logic [pihr_pkg::STEP_W-1:0]      step;
  logic [pihr_pkg::STEP_W-1:0]      pos;
  logic [pihr_pkg::TIME_W:0]        rem_shift;
  logic                             fits;
  logic [pihr_pkg::QUO_W-1:0]       quo_ext;
  logic [pihr_pkg::RATE_W-1:0]      rate;
  logic                             load;
  logic                             out_free;
  logic                             out_valid;
  logic [pihr_pkg::INTERVAL_W-1:0]  out_interval;
  logic [pihr_pkg::RATE_W-1:0]      out_rate;
  logic                             out_zero;

  // one restoring step: bring down the next dividend bit, subtract if it fits
  assign pos       = pihr_pkg::STEP_W'(pihr_pkg::DIV_BITS - 1) - step;
  assign rem_shift = {remainder, pihr_pkg::DIVIDEND[pos]};
  assign fits      = (rem_shift >= {1'b0, divisor});

  // saturate the quotient to the rate field
  assign quo_ext = pihr_pkg::QUO_W'(quotient);
  assign rate    = (quo_ext > pihr_pkg::RATE_MAX) ? '1 : quo_ext[pihr_pkg::RATE_W-1:0];

  assign out_free = !out_valid || results.ready;

  // sequencer
  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load       = 1'b0;
    case (state)
      pihr_pkg::BACK_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = pop_job.zero ? pihr_pkg::BACK_DONE : pihr_pkg::BACK_RUN;
        end
      end
      pihr_pkg::BACK_RUN: begin
        if (step == pihr_pkg::STEP_W'(pihr_pkg::DIV_BITS - 1)) begin
          state_next = pihr_pkg::BACK_DONE;
        end
      end
      pihr_pkg::BACK_DONE: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = pihr_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = pihr_pkg::BACK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pihr_pkg::BACK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (state == pihr_pkg::BACK_IDLE && pop_valid) begin
      divisor   <= pop_job.interval;
      zero      <= pop_job.zero;
      remainder <= '0;
      quotient  <= '0;
      step      <= '0;
    end else if (state == pihr_pkg::BACK_RUN) begin
      remainder <= fits ? rem_shift[pihr_pkg::TIME_W-1:0] - divisor
                        : rem_shift[pihr_pkg::TIME_W-1:0];
      quotient  <= {quotient[pihr_pkg::DIV_BITS-2:0], fits};
      step      <= step + pihr_pkg::STEP_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_interval <= pihr_pkg::INTERVAL_W'(divisor);
      out_rate     <= zero ? '0 : rate;
      out_zero     <= zero;
    end
  end

  assign results.valid         = out_valid;
  assign results.interval_ms   = out_interval;
  assign results.rate_fixed    = out_rate;
  assign results.zero_interval = out_zero;

endmodule

>>> src/pulse_interval_heart_rate.sv
`timescale 1ns / 1ps

// channel   | dir | fields
// ----------+-----+---------------------------------------------------
// samples   | in  | sample_time_ms[31:0], pulse_level, last_sample
// results   | out | interval_ms[31:0], rate_fixed[23:0], zero_interval
//
// a sample transfers whenever the two-entry edge queue has room
// each rising edge after the first of a record is taken from the queue by
// the back end, divided in the 24-bit serial divider (one quotient bit per
// cycle) and then loaded into the result register once that register is free
// a zero interval skips the divider
// synchronous reset clears edge history, queue and divider control
// a stalled result holds in the output register while the next division runs

module pulse_interval_heart_rate (
  input  logic           clk,
  input  logic           rst,
  pihr_sample_if.sink    samples,
  pihr_result_if.source  results
);

  logic           push_valid;
  logic           push_ready;
  pihr_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  pihr_pkg::job_t pop_job;

  pihr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  pihr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  pihr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .results   (results)
  );

endmodule
